### design/modbus_rtu_response_receiver_unit_assert.svh
// ----------------------------------------------------------------------------
// Modbus RTU response receiver - assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef MODBUS_RTU_RESPONSE_RECEIVER_UNIT_ASSERT_SVH
`define MODBUS_RTU_RESPONSE_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is held
`define MRR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define MRR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mrr_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver - package
// Status codes, function codes, frame constants and the CRC byte update.
// ----------------------------------------------------------------------------
package mrr_pkg;

    typedef enum logic [2:0] {
        ST_IGNORED  = 3'd0,
        ST_REJECTED = 3'd1,
        ST_STORED   = 3'd2,
        ST_FRAME_OK = 3'd3,
        ST_CRC_ERR  = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    localparam logic [7:0]  FN_READ        = 8'h03;
    localparam logic [7:0]  FN_WRITE       = 8'h10;
    localparam logic [8:0]  WRITE_ACK_LEN  = 9'd8;
    localparam logic [8:0]  READ_OVERHEAD  = 9'd5;
    localparam logic [15:0] CRC_INIT       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  MAX_ADDR_RESET = 8'd1;
    localparam int          FRAME_BYTES    = 256;

    // CRC-16/MODBUS, one byte, LSB first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/modbus_rtu_response_receiver_unit.sv
// ----------------------------------------------------------------------------
// Modbus RTU response receiver
// Frames master-side Modbus RTU responses byte by byte and checks the CRC.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------
//  in      | to unit   | i_in_valid / o_in_stall   | i_rx_byte
//  out     | from unit | o_out_valid / i_out_stall | o_status .. o_received_crc
//  cfg     | to unit   | i_cfg_valid / o_cfg_ready | i_cfg_data (max_address)
//
//  One item per cycle while the output is not stalled; each byte's result appears in the cycle after it is taken.
//  The framing next-state logic and byte-wide CRC step are combinational in front of the result
//  register, so throughput is set by that register alone.
//  Synchronous active-low reset: hunting for an address, max_address = 1.
//  A stall on the output holds the result and stalls the input in the same cycle.
//  Input is stalled and cfg not ready while reset is held; write only when idle.
//
module modbus_rtu_response_receiver_unit #(
    parameter int FRAME_BYTES = mrr_pkg::FRAME_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_data_byte,
    output logic [7:0]  o_position,
    output logic [7:0]  o_frame_address,
    output logic [7:0]  o_function_code,
    output logic [8:0]  o_frame_length,
    output logic [15:0] o_computed_crc,
    output logic [15:0] o_received_crc,
    // max_address write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int POS_W = $clog2(FRAME_BYTES);   // index of next byte, < FRAME_BYTES
    localparam int CNT_W = POS_W + 1;             // count can reach FRAME_BYTES
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;

    // framing state
    logic [7:0]       r_max_addr;
    logic [POS_W-1:0] r_pos,   n_pos;
    logic [7:0]       r_addr,  n_addr;
    logic [7:0]       r_func,  n_func;
    logic [7:0]       r_bcnt,  n_bcnt;
    logic [15:0]      r_crc,   n_crc;     // CRC lagging two bytes behind
    logic [15:0]      r_last2, n_last2;   // newest byte in the low half

    // result register
    logic             r_out_valid;
    mrr_pkg::t_status r_status,   n_status;
    logic [7:0]       r_data;
    logic [7:0]       r_position, n_position;
    logic [7:0]       r_faddr,    n_faddr;
    logic [7:0]       r_fcode,    n_fcode;
    logic [8:0]       r_flen,     n_flen;
    logic [15:0]      r_ccrc,     n_ccrc;
    logic [15:0]      r_rcrc,     n_rcrc;

    logic             in_acc;
    logic [CNT_W-1:0] count;
    logic [8:0]       total;
    logic [7:0]       bcnt_eff;
    logic [15:0]      crc_upd;
    logic [15:0]      last2_upd;
    logic             is_end;

    // terms for the checks
    logic             chk_closed;
    logic             chk_hunting;
    logic             chk_ok;
    logic             chk_body;
    logic             chk_func_ok;

    // nothing is taken while reset is held
    assign o_in_stall  = !i_rst_n || (r_out_valid && i_out_stall);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = i_rst_n;

    // shared terms for bytes past the function code
    assign count     = CNT_W'({1'b0, r_pos}) + CNT_W'(1);
    assign bcnt_eff  = (r_pos == POS_W'(2)) ? i_rx_byte : r_bcnt;
    assign total     = {1'b0, bcnt_eff} + mrr_pkg::READ_OVERHEAD;
    assign crc_upd   = mrr_pkg::crc_byte(r_crc, r_last2[15:8]);
    assign last2_upd = {r_last2[7:0], i_rx_byte};

    always_comb begin
        n_pos      = r_pos;
        n_addr     = r_addr;
        n_func     = r_func;
        n_bcnt     = r_bcnt;
        n_crc      = r_crc;
        n_last2    = r_last2;
        n_status   = mrr_pkg::ST_IGNORED;
        n_position = 8'd0;
        n_faddr    = 8'd0;
        n_fcode    = 8'd0;
        n_flen     = 9'd0;
        n_ccrc     = 16'd0;
        n_rcrc     = 16'd0;
        is_end     = 1'b0;

        if (r_pos == POS_W'(0)) begin
            // hunting: only an address in 1..max_address opens a frame
            if (i_rx_byte != 8'd0 && i_rx_byte <= r_max_addr) begin
                n_addr   = i_rx_byte;
                n_func   = 8'd0;
                n_bcnt   = 8'd0;
                n_crc    = mrr_pkg::CRC_INIT;
                n_last2  = {8'd0, i_rx_byte};
                n_pos    = POS_W'(1);
                n_status = mrr_pkg::ST_STORED;
                n_faddr  = i_rx_byte;
            end
        end else if (r_pos == POS_W'(1)) begin
            n_position = 8'd1;
            n_faddr    = r_addr;
            n_fcode    = i_rx_byte;
            if (i_rx_byte == mrr_pkg::FN_READ || i_rx_byte == mrr_pkg::FN_WRITE) begin
                n_func   = i_rx_byte;
                n_last2  = {r_last2[7:0], i_rx_byte};
                n_pos    = POS_W'(2);
                n_status = mrr_pkg::ST_STORED;
            end else begin
                // bad function: back to hunting from the next byte
                n_pos    = POS_W'(0);
                n_status = mrr_pkg::ST_REJECTED;
            end
        end else begin
            n_bcnt     = bcnt_eff;
            n_crc      = crc_upd;
            n_last2    = last2_upd;
            n_position = 8'(r_pos);
            n_faddr    = r_addr;
            n_fcode    = r_func;
            n_status   = mrr_pkg::ST_STORED;
            n_pos      = POS_W'(count);

            if (r_func == mrr_pkg::FN_READ) begin
                if (CMP_W'(count) >= CMP_W'(total)) begin
                    is_end = 1'b1;
                end else if (CMP_W'(count) >= CMP_W'(FRAME_BYTES)) begin
                    n_status = mrr_pkg::ST_OVERFLOW;
                    n_pos    = POS_W'(0);
                end
            end else if (r_func == mrr_pkg::FN_WRITE) begin
                if (CMP_W'(count) >= CMP_W'(mrr_pkg::WRITE_ACK_LEN)) begin
                    is_end = 1'b1;
                end
            end else if (CMP_W'(count) >= CMP_W'(FRAME_BYTES)) begin
                n_status = mrr_pkg::ST_OVERFLOW;
                n_pos    = POS_W'(0);
            end

            if (is_end) begin
                // CRC field arrives low byte first
                n_flen   = 9'(count);
                n_ccrc   = crc_upd;
                n_rcrc   = {last2_upd[7:0], last2_upd[15:8]};
                n_status = (crc_upd == {last2_upd[7:0], last2_upd[15:8]})
                         ? mrr_pkg::ST_FRAME_OK : mrr_pkg::ST_CRC_ERR;
                n_pos    = POS_W'(0);
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_addr  <= mrr_pkg::MAX_ADDR_RESET;
            r_pos       <= '0;
            r_addr      <= 8'd0;
            r_func      <= 8'd0;
            r_bcnt      <= 8'd0;
            r_crc       <= mrr_pkg::CRC_INIT;
            r_last2     <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_addr <= i_cfg_data;
            end
            if (in_acc) begin
                r_pos   <= n_pos;
                r_addr  <= n_addr;
                r_func  <= n_func;
                r_bcnt  <= n_bcnt;
                r_crc   <= n_crc;
                r_last2 <= n_last2;
            end
            if (in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded with each accepted item
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_status   <= n_status;
            r_data     <= i_rx_byte;
            r_position <= n_position;
            r_faddr    <= n_faddr;
            r_fcode    <= n_fcode;
            r_flen     <= n_flen;
            r_ccrc     <= n_ccrc;
            r_rcrc     <= n_rcrc;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_data_byte     = r_data;
    assign o_position      = r_position;
    assign o_frame_address = r_faddr;
    assign o_function_code = r_fcode;
    assign o_frame_length  = r_flen;
    assign o_computed_crc  = r_ccrc;
    assign o_received_crc  = r_rcrc;

    // ------------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------------
`include "modbus_rtu_response_receiver_unit_assert.svh"

    assign chk_closed  = r_out_valid && (r_status == mrr_pkg::ST_FRAME_OK
                                      || r_status == mrr_pkg::ST_CRC_ERR
                                      || r_status == mrr_pkg::ST_OVERFLOW
                                      || r_status == mrr_pkg::ST_REJECTED);
    assign chk_hunting = (r_pos == POS_W'(0));
    assign chk_ok      = r_out_valid && (r_status == mrr_pkg::ST_FRAME_OK);
    assign chk_body    = (r_pos >= POS_W'(2));
    assign chk_func_ok = (r_func == mrr_pkg::FN_READ) || (r_func == mrr_pkg::FN_WRITE);

    // every accepted byte leaves a result behind it
    `MRR_ASSERT_NEXT(a_item_gives_result, i_clk, i_rst_n, in_acc, r_out_valid, "item lost")

    // a frame end, reject or overflow always returns the framer to hunting
    `MRR_ASSERT_NOW(a_end_hunts, i_clk, i_rst_n, chk_closed, chk_hunting, "closed, not hunting")

    // good frame means the two CRCs agree
    `MRR_ASSERT_NOW(a_ok_crc_match, i_clk, i_rst_n, chk_ok, r_ccrc == r_rcrc, "ok, CRC differs")

    // past the function byte only read or write frames are tracked
    `MRR_ASSERT_NOW(a_func_known, i_clk, i_rst_n, chk_body, chk_func_ok, "unknown function")

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modbus RTU response receiver - testbench
// Feeds byte streams (well-formed read and write responses, bad CRCs,
// rejected function codes, truncated frames, an overflowing frame and
// line noise) through the receiver under several max_address settings. Each
// accepted byte is run through a local framing and CRC-16 predictor, and every
// result item is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    // one predicted result item, one per accepted byte
    typedef struct {
        mrr_pkg::t_status status;
        logic [7:0]       data_byte;
        logic [7:0]       position;
        logic [7:0]       frame_address;
        logic [7:0]       function_code;
        logic [8:0]       frame_length;
        logic [15:0]      computed_crc;
        logic [15:0]      received_crc;
    } t_rx_result;

    localparam int QUIET_LIMIT  = 4000;  // cycles with no item moving
    localparam int RANDOM_ITEMS = 60;
    localparam int MAX_IDLE     = 15;

    // ------------------------------------------------------------------------
    // clock, reset and DUT connections
    // ------------------------------------------------------------------------
    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'h00;

    logic        in_stall;
    logic        out_valid;
    logic        cfg_ready;
    logic [2:0]  status;
    logic [7:0]  data_byte;
    logic [7:0]  position;
    logic [7:0]  frame_address;
    logic [7:0]  function_code;
    logic [8:0]  frame_length;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    modbus_rtu_response_receiver_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_rx_byte       (rx_byte),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_status        (status),
        .o_data_byte     (data_byte),
        .o_position      (position),
        .o_frame_address (frame_address),
        .o_function_code (function_code),
        .o_frame_length  (frame_length),
        .o_computed_crc  (computed_crc),
        .o_received_crc  (received_crc),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: a private copy of the framer and its one register
    // ------------------------------------------------------------------------
    logic [7:0]  addr_limit  = mrr_pkg::MAX_ADDR_RESET;  // max_address as last written
    logic [8:0]  next_index  = '0;                       // index the next byte takes
    logic [7:0]  frame_addr  = '0;
    logic [7:0]  frame_func  = '0;
    logic [7:0]  frame_count = '0;                       // byte-count field of a read
    logic [15:0] crc_behind  = mrr_pkg::CRC_INIT;        // CRC lagging two bytes
    logic [15:0] recent_pair = '0;                       // newest byte in the low half

    t_rx_result expected_results[$];

    // knobs shared between the stimulus and the two handshake sides
    bit src_idle_on  = 1'b0;
    bit sink_idle_on = 1'b0;
    int hold_cycles  = 0;   // long receiver hold-off, counted down by the sink

    int n_errors     = 0;
    int n_items      = 0;
    int n_random     = 0;
    int n_cfg_writes = 0;
    int status_seen[8];

    // CRC-16/MODBUS, reflected, one byte at a time
    function automatic logic [15:0] crc_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8) c = c[0] ? ({1'b0, c[15:1]} ^ mrr_pkg::CRC_POLY) : {1'b0, c[15:1]};
        return c;
    endfunction

    // Advance the framer by one byte and return what the block should report.
    function automatic t_rx_result predict_byte(input logic [7:0] b);
        t_rx_result r;
        int         cnt;
        bit         at_end;
        r.status        = mrr_pkg::ST_IGNORED;
        r.data_byte     = b;
        r.position      = '0;
        r.frame_address = '0;
        r.function_code = '0;
        r.frame_length  = '0;
        r.computed_crc  = '0;
        r.received_crc  = '0;
        if (next_index == 0) begin
            // hunting: only 1..max_address opens a frame
            if (b >= 1 && b <= addr_limit) begin
                frame_addr      = b;
                frame_func      = '0;
                frame_count     = '0;
                crc_behind      = mrr_pkg::CRC_INIT;
                recent_pair     = {8'h00, b};
                next_index      = 9'd1;
                r.status        = mrr_pkg::ST_STORED;
                r.frame_address = b;
            end
        end else if (next_index == 1) begin
            r.position      = 8'd1;
            r.frame_address = frame_addr;
            r.function_code = b;  // the rejected byte is echoed here as well
            if (b == mrr_pkg::FN_READ || b == mrr_pkg::FN_WRITE) begin
                frame_func  = b;
                recent_pair = {recent_pair[7:0], b};
                next_index  = 9'd2;
                r.status    = mrr_pkg::ST_STORED;
            end else begin
                next_index = '0;
                r.status   = mrr_pkg::ST_REJECTED;
            end
        end else begin
            cnt = int'(next_index) + 1;
            if (next_index == 2)
                frame_count = b;
            crc_behind  = crc_update(crc_behind, recent_pair[15:8]);
            recent_pair = {recent_pair[7:0], b};
            r.position      = next_index[7:0];
            r.frame_address = frame_addr;
            r.function_code = frame_func;
            r.status        = mrr_pkg::ST_STORED;
            next_index      = cnt[8:0];
            at_end          = 1'b0;
            if (frame_func == mrr_pkg::FN_READ) begin
                if (cnt >= int'(frame_count) + int'(mrr_pkg::READ_OVERHEAD)) begin
                    at_end = 1'b1;
                end else if (cnt >= mrr_pkg::FRAME_BYTES) begin
                    r.status   = mrr_pkg::ST_OVERFLOW;
                    next_index = '0;
                end
            end else if (frame_func == mrr_pkg::FN_WRITE) begin
                if (cnt >= int'(mrr_pkg::WRITE_ACK_LEN))
                    at_end = 1'b1;
            end else if (cnt >= mrr_pkg::FRAME_BYTES) begin
                r.status   = mrr_pkg::ST_OVERFLOW;
                next_index = '0;
            end
            if (at_end) begin
                r.frame_length = cnt[8:0];
                r.computed_crc = crc_behind;
                r.received_crc = {recent_pair[7:0], recent_pair[15:8]};
                r.status       = (crc_behind == r.received_crc) ? mrr_pkg::ST_FRAME_OK
                                                                : mrr_pkg::ST_CRC_ERR;
                next_index     = '0;
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------------
    // Offers one byte, holds it while stalled, records the prediction once
    // taken. Valid is left high so a back-to-back item needs no dip.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        expected_results.push_back(predict_byte(b));
        n_items++;
    endtask

    // Stop offering and wait until every predicted result has come back,
    // then let the one-stage result register settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_max_address(input logic [7:0] v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        addr_limit = v;
        n_cfg_writes++;
    endtask

    // Builds a response frame (read: count byte plus body; anything else:
    // four body bytes), appends its CRC low byte first, optionally spoils it,
    // and sends the first keep bytes.
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
                              input int body_len, input bit bad_crc, input int keep);
        logic [7:0]  frame_q[$];
        logic [15:0] crc;
        frame_q.push_back(addr);
        frame_q.push_back(fn);
        if (fn == mrr_pkg::FN_READ) begin
            frame_q.push_back(body_len[7:0]);
            repeat (body_len) frame_q.push_back(8'($urandom));
        end else begin
            repeat (4) frame_q.push_back(8'($urandom));
        end
        crc = mrr_pkg::CRC_INIT;
        foreach (frame_q[k]) crc = crc_update(crc, frame_q[k]);
        if (bad_crc)
            crc ^= 16'($urandom_range(1, 16'hFFFF));
        frame_q.push_back(crc[7:0]);
        frame_q.push_back(crc[15:8]);
        foreach (frame_q[k]) begin
            if (k < keep)
                send_byte(frame_q[k]);
        end
    endtask

    // ------------------------------------------------------------------------
    // receiver side: random stall per result item, plus the long hold-off
    // ------------------------------------------------------------------------
    int sink_wait = 0;

    always @(posedge clk) begin
        if (!rst_n) begin
            sink_wait = 0;
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall)
                sink_wait = sink_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            else if (sink_wait > 0)
                sink_wait--;
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= (sink_wait > 0);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------
    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $display("%0t: %s expected %0h, actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk) begin : result_check
        t_rx_result want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected nothing, actual status %0d byte %02h",
                         $time, status, data_byte);
            end else begin
                want = expected_results.pop_front();
                check_field("status",        want.status,        status);
                check_field("data_byte",     want.data_byte,     data_byte);
                check_field("position",      want.position,      position);
                check_field("frame_address", want.frame_address, frame_address);
                check_field("function_code", want.function_code, function_code);
                check_field("frame_length",  want.frame_length,  frame_length);
                check_field("computed_crc",  want.computed_crc,  computed_crc);
                check_field("received_crc",  want.received_crc,  received_crc);
                status_seen[want.status]++;
            end
        end
    end

    // watchdog: ends the run if neither side moves an item for too long
    int quiet_cycles = 0;

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles, %0d results outstanding",
                     $time, quiet_cycles, expected_results.size());
            $display("modbus_rtu_response_receiver_unit: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    // max_address straight out of reset is 1
    task automatic test_reset_limit();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        send_byte(8'h00);                     // address 0 never opens a frame
        send_byte(8'h02);                     // just above the limit
        send_byte(8'hFF);
        send_frame(8'h01, mrr_pkg::FN_READ, 2, 1'b0, 999);
        send_frame(8'h01, mrr_pkg::FN_WRITE, 0, 1'b1, 999);
    endtask

    task automatic test_function_codes();
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        send_byte(8'h01);
        send_byte(8'h01);                     // rejected, and not retried as address
        send_byte(8'h04);
        send_byte(8'h01);
        send_byte(8'hEF);                     // rejected
        send_frame(8'h01, mrr_pkg::FN_READ, 0, 1'b0, 999);   // shortest read
        send_frame(8'h01, mrr_pkg::FN_READ, 0, 1'b1, 999);
        send_frame(8'h01, mrr_pkg::FN_WRITE, 0, 1'b0, 999);
    endtask

    // both ends of the register and values past the normal address range
    task automatic test_address_limits();
        write_max_address(8'd0);              // nothing is an address
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hF7);
        send_byte(8'hFF);
        write_max_address(8'd247);
        send_frame(8'd247, mrr_pkg::FN_WRITE, 0, 1'b0, 999);
        send_byte(8'd248);                    // just past the limit
        write_max_address(8'd255);
        send_frame(8'd255, mrr_pkg::FN_READ, 1, 1'b0, 999);
    endtask

    // a read one byte too long for the buffer, cut after the dropping byte
    task automatic test_long_frames();
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b1;
        send_frame(8'h02, mrr_pkg::FN_READ, 252, 1'b0, mrr_pkg::FRAME_BYTES);
        drain_results();
    endtask

    task automatic test_backpressure();
        // receiver holds off while the sender keeps pushing back to back
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        hold_cycles  = 100;
        send_frame(8'h05, mrr_pkg::FN_READ, 16, 1'b0, 999);
        drain_results();                      // sender pauses for the backlog
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        hold_cycles  = 40;
        send_frame(8'h06, mrr_pkg::FN_WRITE, 0, 1'b0, 999);
        drain_results();
    endtask

    task automatic test_random_traffic();
        int         pick;
        int         phase;
        int         body;
        logic [7:0] fn;
        logic [7:0] addr;
        int         start;
        start = n_items;
        phase = 0;
        while (n_items - start < RANDOM_ITEMS) begin
            // new phase every fifteen items or so: idle pattern and limit
            if (n_items - start >= phase * 15) begin
                case (phase % 4)
                    0: write_max_address(8'd247);
                    1: write_max_address(8'd1);
                    2: write_max_address(8'($urandom_range(2, 254)));
                    default: write_max_address(8'd255);
                endcase
                src_idle_on  = (phase % 4 == 0) || (phase % 4 == 2);
                sink_idle_on = (phase % 4 == 0) || (phase % 4 == 3);
                phase++;
            end
            pick = $urandom_range(0, 99);
            addr = 8'($urandom_range(1, addr_limit));
            fn   = $urandom_range(0, 1) ? mrr_pkg::FN_READ : mrr_pkg::FN_WRITE;
            body = (pick < 10) ? $urandom_range(13, 40) : $urandom_range(0, 12);
            if (pick < 70) begin
                send_frame(addr, fn, body, $urandom_range(0, 4) == 0, 999);
            end else if (pick < 80) begin
                // broken frame: cut short, the next bytes run into it
                send_frame(addr, fn, body, 1'b0,
                           $urandom_range(1, (fn == mrr_pkg::FN_READ ? body + 5 : 8) - 1));
            end else if (pick < 90) begin
                do fn = 8'($urandom); while (fn == mrr_pkg::FN_READ || fn == mrr_pkg::FN_WRITE);
                send_byte(addr);
                send_byte(fn);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end
        end
        n_random = n_items - start;
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_limit();
        test_function_codes();
        test_address_limits();
        test_long_frames();
        test_backpressure();
        test_random_traffic();
        drain_results();
        $display("%0d bytes sent (%0d random), %0d max_address writes", n_items, n_random,
                 n_cfg_writes);
        $display("frames ok %0d, crc errors %0d, overflows %0d, rejected %0d, ignored %0d",
                 status_seen[mrr_pkg::ST_FRAME_OK], status_seen[mrr_pkg::ST_CRC_ERR],
                 status_seen[mrr_pkg::ST_OVERFLOW], status_seen[mrr_pkg::ST_REJECTED],
                 status_seen[mrr_pkg::ST_IGNORED]);
        if (n_errors == 0) begin
            $display("modbus_rtu_response_receiver_unit: match");
        end else begin
            $display("modbus_rtu_response_receiver_unit: mismatch");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/mrr_pkg.sv
design/modbus_rtu_response_receiver_unit.sv
dv/tb_top.sv
